/* hw/rtl/dssu_pkg.sv */
package dssu_pkg;

  // Fixed-point formats
  localparam int CHUNK_W   = 16;   // operand digit handled per multiply
  localparam int COEF_W    = 40;   // coefficient width
  localparam int COEF_FRAC = 38;   // coefficient fraction bits
  localparam int N_STATE   = 4;
  localparam int N_DRIVE   = 3;
  localparam int N_TERM    = N_STATE + N_DRIVE;
  localparam int TERM_W    = 3;
  localparam int ACC_GUARD = 3;    // headroom for the seven-term row sum

  // Per-cycle lane control, driven by the sequencer
  typedef struct packed {
    logic              clr;      // clear accumulator (new word accepted)
    logic              mul_en;   // multiply this digit by the coefficient
    logic              top;      // digit is the signed top digit
    logic [TERM_W-1:0] term;     // column: x0..x3, then drives a..c
  } dssu_ctl_t;

  // Decimal mantissa * 10^-exp10 to signed Q2.38, round half up on magnitude
  function automatic logic signed [COEF_W-1:0] dec_q38(input logic [63:0] mant,
                                                       input int exp10,
                                                       input logic neg);
    logic [127:0] v;
    v = 128'(mant) << (COEF_FRAC + 1);
    for (int k = 0; k < exp10; k++) v = v / 128'd10;
    v = (v + 128'd1) >> 1;
    return neg ? $signed(-COEF_W'(v)) : $signed(COEF_W'(v));
  endfunction

  // Row i: A columns for x0..x3, then B columns for drives a..c
  localparam logic signed [COEF_W-1:0] COEF_TAB [N_STATE][N_TERM] = '{
    '{dec_q38(64'd999411495568444, 15, 1'b0), dec_q38(64'd100830960387419, 20, 1'b0),
      dec_q38(64'd224902693821756, 18, 1'b0), dec_q38(64'd29430909213924, 15, 1'b0),
      dec_q38(64'd198237047463068, 16, 1'b0), dec_q38(64'd991184660068532, 17, 1'b1),
      dec_q38(64'd991185814562149, 17, 1'b1)},
    '{dec_q38(64'd100830960387419, 20, 1'b1), dec_q38(64'd999411495568444, 15, 1'b0),
      dec_q38(64'd29430909213924, 15, 1'b1), dec_q38(64'd224902693821756, 18, 1'b0),
      dec_q38(64'd666547200502782, 23, 1'b1), dec_q38(64'd171678352401599, 16, 1'b0),
      dec_q38(64'd171678285746878, 16, 1'b1)},
    '{dec_q38(64'd685042872624856, 19, 1'b0), dec_q38(64'd26901914194539, 20, 1'b1),
      dec_q38(64'd999939993871078, 15, 1'b0), dec_q38(64'd785266328386251, 17, 1'b1),
      dec_q38(64'd67927769461335, 20, 1'b0), dec_q38(64'd341178911449813, 21, 1'b1),
      dec_q38(64'd338098783163537, 21, 1'b1)},
    '{dec_q38(64'd269019141945391, 21, 1'b0), dec_q38(64'd685042872624856, 19, 1'b0),
      dec_q38(64'd785266328386251, 17, 1'b0), dec_q38(64'd999939993871078, 15, 1'b0),
      dec_q38(64'd177831289513944, 23, 1'b0), dec_q38(64'd587382583311719, 21, 1'b0),
      dec_q38(64'd589160896206859, 21, 1'b1)}
  };

endpackage

/* hw/rtl/discrete_state_space_update_core.sv */
// Discrete state-space update: x <= A*x + B*u, four states, three drives.
// Input channel (in_valid/in_ready) carries one word of drive_a..drive_c;
// output channel (out_valid/out_ready) returns the four new state elements.
// Four lanes, one per state row, multiply one 16-bit operand digit by a
// 40-bit coefficient per cycle and accumulate exactly; a merge stage rounds,
// saturates and writes the state and the output register together.
// After a word is accepted the sequencer steps through the columns and
// digits (S_MUL), lets the last product reach the accumulators (S_DRAIN)
// and merges in S_FIN. The word rate is set by the seven columns times the
// digits per operand through each lane's single multiplier. in_ready is
// high only while no word is in the lanes.
// A finished result waits in the output register while the next word is
// taken and processed; if the receiver still stalls when that word is done,
// the merge stage holds until the register frees.
// Reset (rst, synchronous): the stored state goes to zero, the output is
// emptied and the block is ready for a word on the next cycle.
module discrete_state_space_update_core import dssu_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] drive_a,
  input  logic signed [DATA_WIDTH-1:0] drive_b,
  input  logic signed [DATA_WIDTH-1:0] drive_c,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] next_x0,
  output logic signed [DATA_WIDTH-1:0] next_x1,
  output logic signed [DATA_WIDTH-1:0] next_x2,
  output logic signed [DATA_WIDTH-1:0] next_x3
);

  localparam int NCH   = (DATA_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int CH_W  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int EXT_W = NCH * CHUNK_W;
  localparam int ACC_W = DATA_WIDTH + COEF_W + ACC_GUARD;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DRAIN, S_FIN} state_t;

  state_t                      state;
  logic [TERM_W-1:0]           term;
  logic [CH_W-1:0]             chunk;
  logic signed [DATA_WIDTH-1:0] drv   [N_DRIVE];
  logic signed [DATA_WIDTH-1:0] plant [N_STATE];
  logic signed [DATA_WIDTH-1:0] nx    [N_STATE];
  logic signed [DATA_WIDTH-1:0] res   [N_STATE];
  logic signed [ACC_W-1:0]     lane_acc [N_STATE];
  logic signed [DATA_WIDTH-1:0] opnd;
  logic signed [EXT_W-1:0]     opnd_ext;
  logic [CHUNK_W-1:0]          digit;
  logic                        accept;
  dssu_ctl_t                   ctl;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Column operand: stored state first, then the drives of the word
  always_comb begin
    if (term < TERM_W'(N_STATE)) begin
      opnd = plant[term[1:0]];
    end else if (term < TERM_W'(N_TERM)) begin
      opnd = drv[2'(term - TERM_W'(N_STATE))];
    end else begin
      opnd = '0;
    end
  end

  assign opnd_ext = EXT_W'(opnd);
  assign digit    = opnd_ext[chunk * CHUNK_W +: CHUNK_W];

  // Lane control
  always_comb begin
    ctl.clr    = accept;
    ctl.mul_en = (state == S_MUL);
    ctl.top    = (chunk == CH_W'(NCH - 1));
    ctl.term   = term;
  end

  // One lane and one round/saturate per state row
  for (genvar g = 0; g < N_STATE; g++) begin : g_row
    dssu_lane #(.DATA_WIDTH(DATA_WIDTH), .ROW(g)) u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .chunk_idx (chunk),
      .digit     (digit),
      .acc       (lane_acc[g])
    );

    dssu_rndsat #(.DATA_WIDTH(DATA_WIDTH)) u_rndsat (
      .acc (lane_acc[g]),
      .res (res[g])
    );
  end

  // Sequencer, state store and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      term      <= '0;
      chunk     <= '0;
      for (int i = 0; i < N_STATE; i++) plant[i] <= '0;
    end else begin
      // Output word leaves; in S_FIN the merge below refills the register
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            drv[0] <= drive_a;
            drv[1] <= drive_b;
            drv[2] <= drive_c;
            term   <= '0;
            chunk  <= '0;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          if (chunk == CH_W'(NCH - 1)) begin
            chunk <= '0;
            if (term == TERM_W'(N_TERM - 1)) begin
              state <= S_DRAIN;
            end else begin
              term <= term + 1'b1;
            end
          end else begin
            chunk <= chunk + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            for (int i = 0; i < N_STATE; i++) begin
              plant[i] <= res[i];
              nx[i]    <= res[i];
            end
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign next_x0 = nx[0];
  assign next_x1 = nx[1];
  assign next_x2 = nx[2];
  assign next_x3 = nx[3];

endmodule

/* hw/rtl/dssu_lane.sv */
module dssu_lane import dssu_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int ROW = 0,
  localparam int NCH = (DATA_WIDTH + CHUNK_W - 1) / CHUNK_W,
  localparam int CH_W = (NCH > 1) ? $clog2(NCH) : 1,
  localparam int ACC_W = DATA_WIDTH + COEF_W + ACC_GUARD
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dssu_ctl_t               ctl,
  input  logic [CH_W-1:0]         chunk_idx,
  input  logic [CHUNK_W-1:0]      digit,
  output logic signed [ACC_W-1:0] acc
);

  localparam int PROD_W = CHUNK_W + 1 + COEF_W;

  logic signed [COEF_W-1:0]  coef;
  logic signed [CHUNK_W:0]   dig;
  logic signed [PROD_W-1:0]  prod;
  logic [CH_W-1:0]           chunk_d;
  logic                      mul_v;
  logic signed [ACC_W-1:0]   addend;

  // Coefficient of this row for the current column
  assign coef = (ctl.term < TERM_W'(N_TERM)) ? COEF_TAB[ROW][ctl.term] : '0;

  // Low digits are unsigned, the top digit carries the sign
  assign dig = ctl.top ? $signed({digit[CHUNK_W-1], digit}) : $signed({1'b0, digit});

  // Product register
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod    <= dig * coef;
      chunk_d <= chunk_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v <= 1'b0;
    end else begin
      mul_v <= ctl.mul_en;
    end
  end

  // Weight the partial product by its digit position
  assign addend = ACC_W'(prod) <<< (CHUNK_W * chunk_d);

  // Exact row accumulator
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc <= '0;
    end else if (mul_v) begin
      acc <= acc + addend;
    end
  end

endmodule

/* hw/rtl/dssu_rndsat.sv */
module dssu_rndsat import dssu_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  localparam int ACC_W = DATA_WIDTH + COEF_W + ACC_GUARD
) (
  input  logic signed [ACC_W-1:0]      acc,
  output logic signed [DATA_WIDTH-1:0] res
);

  localparam int SH_W = ACC_W - COEF_FRAC;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

  logic signed [ACC_W-1:0]          biased;
  logic signed [SH_W-1:0]           shifted;
  logic [SH_W-DATA_WIDTH:0]         upper;
  logic                             fits;

  // Round to nearest, ties up, then drop the fraction
  assign biased  = acc + HALF;
  assign shifted = SH_W'(biased >>> COEF_FRAC);

  // In range when all bits above the result sign agree
  assign upper = shifted[SH_W-1:DATA_WIDTH-1];
  assign fits  = (&upper) | ~(|upper);

  always_comb begin
    if (fits) begin
      res = shifted[DATA_WIDTH-1:0];
    end else if (shifted[SH_W-1]) begin
      res = SAT_MIN;
    end else begin
      res = SAT_MAX;
    end
  end

endmodule

/* hw/rtl/dssu_checker.sv */
module dssu_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [DATA_WIDTH-1:0] drive_a,
  input logic [DATA_WIDTH-1:0] drive_b,
  input logic [DATA_WIDTH-1:0] drive_c,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] next_x0,
  input logic [DATA_WIDTH-1:0] next_x1,
  input logic [DATA_WIDTH-1:0] next_x2,
  input logic [DATA_WIDTH-1:0] next_x3
);

  // After reset: output empty, ready for a word
  a_reset: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("state after reset wrong");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_x0) && $stable(next_x1)
      && $stable(next_x2) && $stable(next_x3))
    else $error("stalled result changed");

  // One word at a time in the lanes
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while busy");

  // No result can appear right after a word is taken
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early");

  logic unused_ok;
  assign unused_ok = ^{drive_a, drive_b, drive_c};

endmodule

bind discrete_state_space_update_core dssu_checker #(.DATA_WIDTH(DATA_WIDTH)) u_dssu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .drive_a   (drive_a),
  .drive_b   (drive_b),
  .drive_c   (drive_c),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .next_x0   (next_x0),
  .next_x1   (next_x1),
  .next_x2   (next_x2),
  .next_x3   (next_x3)
);
